// File: rtl/wpda_pkg.sv
// shared types, constants and codes of the position delta accumulator
package wpda_pkg;

	localparam int SAMPLE_BITS   = 10;
	localparam int TOTAL_BITS    = 32;
	localparam int TRACKER_LIMIT = 255;
	localparam int TRACKER_BITS  = 8;
	localparam int OP_BITS       = 3;
	localparam int MODE_BITS     = 2;
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = 1;
	localparam int QUEUE_DEPTH   = 4;

	typedef enum logic [OP_BITS-1:0] {
		OP_SAMPLE    = 3'd0,
		OP_TRACK     = 3'd1,
		OP_UNTRACK   = 3'd2,
		OP_CAL_BEGIN = 3'd3,
		OP_CAL_END   = 3'd4,
		OP_CLEAR     = 3'd5,
		OP_SET_CAL   = 3'd6,
		OP_NOP       = 3'd7
	} wpda_op_t;

	localparam logic [CFG_IDX_BITS-1:0] CFG_REVERSE_LEFT  = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_REVERSE_RIGHT = 1'd1;

	localparam logic [MODE_BITS-1:0] MODE_IDLE      = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_TRACKING  = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_CAL_START = 2'd2;
	localparam logic [MODE_BITS-1:0] MODE_CAL_RUN   = 2'd3;

	typedef struct packed {
		logic [OP_BITS-1:0]     opcode;
		logic [SAMPLE_BITS-1:0] sample_left;
		logic [SAMPLE_BITS-1:0] sample_right;
		logic                   clear_left;
		logic                   clear_right;
		logic [SAMPLE_BITS-1:0] new_left_min;
		logic [SAMPLE_BITS-1:0] new_left_max;
		logic [SAMPLE_BITS-1:0] new_right_min;
		logic [SAMPLE_BITS-1:0] new_right_max;
	} wpda_in_t;

	typedef struct packed {
		logic signed [TOTAL_BITS-1:0] acc_left;
		logic signed [TOTAL_BITS-1:0] acc_right;
		logic [MODE_BITS-1:0]         mode;
		logic [TRACKER_BITS-1:0]      trackers;
		logic [SAMPLE_BITS-1:0]       cal_lo_left;
		logic [SAMPLE_BITS-1:0]       cal_hi_left;
		logic [SAMPLE_BITS-1:0]       cal_lo_right;
		logic [SAMPLE_BITS-1:0]       cal_hi_right;
		logic [SAMPLE_BITS-1:0]       last_left;
		logic [SAMPLE_BITS-1:0]       last_right;
		logic                         ack;
	} wpda_out_t;

	typedef struct packed {
		logic sample;
		logic track;
		logic untrack;
		logic cal_begin;
		logic cal_end;
		logic clear;
		logic set_cal;
	} wpda_kind_t;

	typedef struct packed {
		wpda_kind_t             kind;
		logic [SAMPLE_BITS-1:0] sample_l;
		logic [SAMPLE_BITS-1:0] sample_r;
		logic                   clr_l;
		logic                   clr_r;
		logic [SAMPLE_BITS-1:0] lmin;
		logic [SAMPLE_BITS-1:0] lmax;
		logic [SAMPLE_BITS-1:0] rmin;
		logic [SAMPLE_BITS-1:0] rmax;
	} wpda_cmd_t;

	typedef struct packed {
		logic reverse_left;
		logic reverse_right;
	} wpda_cfg_t;

endpackage

// File: rtl/wpda_front.sv
// front end: accepts items and decodes the opcode into command flags
module wpda_front (
	input  logic                push,
	output logic                full,
	input  wpda_pkg::wpda_in_t  item,
	output logic                q_wr,
	output wpda_pkg::wpda_cmd_t q_data,
	input  logic                q_full
);
	import wpda_pkg::*;

	wpda_op_t   op;
	wpda_kind_t kind;

	always_comb begin
		op   = wpda_op_t'(item.opcode);
		kind = '0;
		unique case (op)
			OP_SAMPLE:    kind.sample    = 1'b1;
			OP_TRACK:     kind.track     = 1'b1;
			OP_UNTRACK:   kind.untrack   = 1'b1;
			OP_CAL_BEGIN: kind.cal_begin = 1'b1;
			OP_CAL_END:   kind.cal_end   = 1'b1;
			OP_CLEAR:     kind.clear     = 1'b1;
			OP_SET_CAL:   kind.set_cal   = 1'b1;
			OP_NOP:       kind           = '0;
			default:      kind           = '0;
		endcase
	end

	// unused code still yields a result, so it is queued with no flags
	assign q_data = '{kind:     kind,
	                  sample_l: item.sample_left,
	                  sample_r: item.sample_right,
	                  clr_l:    item.clear_left,
	                  clr_r:    item.clear_right,
	                  lmin:     item.new_left_min,
	                  lmax:     item.new_left_max,
	                  rmin:     item.new_right_min,
	                  rmax:     item.new_right_max};
	assign q_wr   = push & ~q_full;
	assign full   = q_full;

endmodule

// File: rtl/wpda_cmd_queue.sv
// short command queue between the front end and the execution back end
module wpda_cmd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  wpda_pkg::wpda_cmd_t wr_data,
	output logic                full,
	input  logic                rd_en,
	output wpda_pkg::wpda_cmd_t rd_data,
	output logic                empty
);
	import wpda_pkg::*;

	localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam logic [PTR_BITS-1:0] LAST_PTR  = PTR_BITS'(QUEUE_DEPTH - 1);
	localparam logic [PTR_BITS:0]   DEPTH_CNT = (PTR_BITS + 1)'(QUEUE_DEPTH);

	wpda_cmd_t             mem_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0]   wr_ptr_q;
	logic [PTR_BITS-1:0]   rd_ptr_q;
	logic [PTR_BITS:0]     count_q;
	logic                  do_wr;
	logic                  do_rd;

	assign full    = (count_q == DEPTH_CNT);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/wpda_back.sv
// back end: executes commands on the tracker state and holds the result register
module wpda_back (
	input  logic                clk,
	input  logic                arst_n,
	input  wpda_pkg::wpda_cfg_t cfg,
	input  logic                cmd_valid,
	input  wpda_pkg::wpda_cmd_t cmd,
	output logic                cmd_take,
	output logic                empty,
	input  logic                pop,
	output wpda_pkg::wpda_out_t result
);
	import wpda_pkg::*;

	localparam int DW = SAMPLE_BITS + 3;
	localparam logic [TRACKER_BITS-1:0] LIMIT    = TRACKER_BITS'(TRACKER_LIMIT);
	localparam logic [SAMPLE_BITS-1:0]  ALL_ONES = '1;

	typedef enum logic [3:0] {
		ST_IDLE      = 4'b0001,
		ST_TRACKING  = 4'b0010,
		ST_CAL_START = 4'b0100,
		ST_CAL_RUN   = 4'b1000
	} mode_state_t;

	function automatic logic [SAMPLE_BITS-1:0] clamp(
		input logic [SAMPLE_BITS-1:0] v,
		input logic [SAMPLE_BITS-1:0] lo,
		input logic [SAMPLE_BITS-1:0] hi
	);
		logic [SAMPLE_BITS-1:0] r;
		r = v;
		if (r < lo) r = lo;
		if (r > hi) r = hi;
		return r;
	endfunction

	// shorter way round; a tie takes the wrapped delta
	function automatic logic signed [DW-1:0] unwrap(
		input logic [SAMPLE_BITS-1:0] cur,
		input logic [SAMPLE_BITS-1:0] last,
		input logic [SAMPLE_BITS-1:0] lo,
		input logic [SAMPLE_BITS-1:0] hi
	);
		logic signed [DW-1:0] rng;
		logic signed [DW-1:0] d;
		logic signed [DW-1:0] w;
		logic signed [DW-1:0] ad;
		logic signed [DW-1:0] aw;
		rng = $signed(DW'(hi) - DW'(lo) + DW'(1));
		d   = $signed(DW'(clamp(cur, lo, hi)) - DW'(clamp(last, lo, hi)));
		w   = (d > 0) ? d - rng : d + rng;
		ad  = (d < 0) ? -d : d;
		aw  = (w < 0) ? -w : w;
		return (ad < aw) ? d : w;
	endfunction

	function automatic logic signed [TOTAL_BITS-1:0] sat_add(
		input logic signed [TOTAL_BITS-1:0] t,
		input logic signed [DW-1:0]         d
	);
		logic [TOTAL_BITS:0] s;
		s = {t[TOTAL_BITS-1], t} + {{(TOTAL_BITS + 1 - DW){d[DW-1]}}, d};
		if (s[TOTAL_BITS] != s[TOTAL_BITS-1]) begin
			return s[TOTAL_BITS] ? {1'b1, {(TOTAL_BITS - 1){1'b0}}}
			                     : {1'b0, {(TOTAL_BITS - 1){1'b1}}};
		end
		return $signed(s[TOTAL_BITS-1:0]);
	endfunction

	function automatic logic [MODE_BITS-1:0] mode_code(input mode_state_t m);
		logic [MODE_BITS-1:0] c;
		unique case (m)
			ST_IDLE:      c = MODE_IDLE;
			ST_TRACKING:  c = MODE_TRACKING;
			ST_CAL_START: c = MODE_CAL_START;
			ST_CAL_RUN:   c = MODE_CAL_RUN;
			default:      c = MODE_IDLE;
		endcase
		return c;
	endfunction

	mode_state_t                  mode_q, mode_d;
	logic [TRACKER_BITS-1:0]      trackers_q, trackers_d;
	logic                         autocal_q, autocal_d;
	logic                         seed_q, seed_d;
	logic [SAMPLE_BITS-1:0]       prev_l_q, prev_l_d, prev_r_q, prev_r_d;
	logic signed [TOTAL_BITS-1:0] total_l_q, total_l_d, total_r_q, total_r_d;
	logic [SAMPLE_BITS-1:0]       lo_l_q, lo_l_d, hi_l_q, hi_l_d;
	logic [SAMPLE_BITS-1:0]       lo_r_q, lo_r_d, hi_r_q, hi_r_d;
	logic                         ack_d;
	logic                         out_valid_q;
	wpda_out_t                    result_q;
	logic [SAMPLE_BITS-1:0]       base_l, base_r;
	logic signed [DW-1:0]         dl, dr;

	assign cmd_take = cmd_valid & (~out_valid_q | pop);
	assign empty    = ~out_valid_q;
	assign result   = result_q;

	assign base_l = seed_q ? cmd.sample_l : prev_l_q;
	assign base_r = seed_q ? cmd.sample_r : prev_r_q;
	assign dl     = unwrap(cmd.sample_l, base_l, lo_l_q, hi_l_q);
	assign dr     = unwrap(cmd.sample_r, base_r, lo_r_q, hi_r_q);

	always_comb begin
		mode_d     = mode_q;
		trackers_d = trackers_q;
		autocal_d  = autocal_q;
		seed_d     = seed_q;
		prev_l_d   = prev_l_q;
		prev_r_d   = prev_r_q;
		total_l_d  = total_l_q;
		total_r_d  = total_r_q;
		lo_l_d     = lo_l_q;
		hi_l_d     = hi_l_q;
		lo_r_d     = lo_r_q;
		hi_r_d     = hi_r_q;
		ack_d      = 1'b0;
		if (cmd.kind.sample) begin
			unique case (mode_q)
				ST_IDLE: begin
					if (trackers_q != '0) begin
						mode_d = ST_TRACKING;
						seed_d = 1'b1;
					end
				end
				ST_TRACKING: begin
					if (trackers_q == '0) begin
						mode_d = ST_IDLE;
					end else begin
						seed_d    = 1'b0;
						total_l_d = sat_add(total_l_q, cfg.reverse_left ? -dl : dl);
						total_r_d = sat_add(total_r_q, cfg.reverse_right ? -dr : dr);
						prev_l_d  = cmd.sample_l;
						prev_r_d  = cmd.sample_r;
					end
				end
				ST_CAL_START: begin
					if (!autocal_q) begin
						mode_d = ST_IDLE;
					end else begin
						lo_l_d = ALL_ONES;
						hi_l_d = '0;
						lo_r_d = ALL_ONES;
						hi_r_d = '0;
						mode_d = ST_CAL_RUN;
					end
				end
				ST_CAL_RUN: begin
					if (!autocal_q) begin
						mode_d = ST_IDLE;
					end else begin
						if (cmd.sample_l < lo_l_q) lo_l_d = cmd.sample_l;
						if (cmd.sample_l > hi_l_q) hi_l_d = cmd.sample_l;
						if (cmd.sample_r < lo_r_q) lo_r_d = cmd.sample_r;
						if (cmd.sample_r > hi_r_q) hi_r_d = cmd.sample_r;
					end
				end
				default: mode_d = ST_IDLE;
			endcase
		end
		if (cmd.kind.track && trackers_q < LIMIT) begin
			if (trackers_q == '0 && mode_q == ST_IDLE) begin
				mode_d = ST_TRACKING;
				seed_d = 1'b1;
			end
			trackers_d = trackers_q + 1'b1;
		end
		if (cmd.kind.untrack && trackers_q != '0) begin
			trackers_d = trackers_q - 1'b1;
			if (trackers_q == TRACKER_BITS'(1)) mode_d = ST_IDLE;
		end
		if (cmd.kind.cal_begin) begin
			autocal_d = 1'b1;
			if (mode_q == ST_IDLE || mode_q == ST_TRACKING) mode_d = ST_CAL_START;
		end
		if (cmd.kind.cal_end && autocal_q) begin
			if (mode_q == ST_CAL_START || mode_q == ST_CAL_RUN) mode_d = ST_IDLE;
			autocal_d = 1'b0;
			ack_d     = 1'b1;
		end
		if (cmd.kind.clear) begin
			if (cmd.clr_l) total_l_d = '0;
			if (cmd.clr_r) total_r_d = '0;
		end
		if (cmd.kind.set_cal) begin
			lo_l_d = cmd.lmin;
			hi_l_d = cmd.lmax;
			lo_r_d = cmd.rmin;
			hi_r_d = cmd.rmax;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= ST_IDLE;
			trackers_q  <= '0;
			autocal_q   <= 1'b0;
			seed_q      <= 1'b1;
			prev_l_q    <= '0;
			prev_r_q    <= '0;
			total_l_q   <= '0;
			total_r_q   <= '0;
			lo_l_q      <= ALL_ONES;
			hi_l_q      <= '0;
			lo_r_q      <= ALL_ONES;
			hi_r_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_take) begin
				mode_q     <= mode_d;
				trackers_q <= trackers_d;
				autocal_q  <= autocal_d;
				seed_q     <= seed_d;
				prev_l_q   <= prev_l_d;
				prev_r_q   <= prev_r_d;
				total_l_q  <= total_l_d;
				total_r_q  <= total_r_d;
				lo_l_q     <= lo_l_d;
				hi_l_q     <= hi_l_d;
				lo_r_q     <= lo_r_d;
				hi_r_q     <= hi_r_d;
			end
			if (cmd_take) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			result_q <= '{acc_left:     total_l_d,
			              acc_right:    total_r_d,
			              mode:         mode_code(mode_d),
			              trackers:     trackers_d,
			              cal_lo_left:  lo_l_d,
			              cal_hi_left:  hi_l_d,
			              cal_lo_right: lo_r_d,
			              cal_hi_right: hi_r_d,
			              last_left:    prev_l_d,
			              last_right:   prev_r_d,
			              ack:          ack_d};
		end
	end

endmodule

// File: rtl/wrapping_position_delta_accumulator.sv
// top level of the wrapping position delta accumulator
//
//  channel  | direction | handshake          | transaction moves
//  ---------+-----------+--------------------+------------------------------
//  item     | in        | push / full        | opcode, readings, clear, cal
//  result   | out       | pop / empty        | totals, mode, count, cal, ack
//  cfg      | in        | cfg_we             | reverse flag at cfg_idx
//
// one item a cycle sustained while results are popped; each item is written to
//   the queue, then executed into the output register that drives the ports
// the execute stage is combinational into the output register: clamp, shortest-way delta, saturating add
// a stalled result holds the output register; the queue keeps taking items
//   until it is full, then full rises
// reset clears the control and tracker state at once; no clearing pass
module wrapping_position_delta_accumulator (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  wpda_pkg::wpda_in_t                    item,
	output logic                                  empty,
	input  logic                                  pop,
	output wpda_pkg::wpda_out_t                   result,
	input  logic                                  cfg_we,
	input  logic [wpda_pkg::CFG_IDX_BITS-1:0]     cfg_idx,
	input  logic [wpda_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);
	import wpda_pkg::*;

	// configuration flags; the user must write them only while idle, not enforced here
	wpda_cfg_t cfg_q;

	// front to queue
	logic      q_wr;
	logic      q_full;
	wpda_cmd_t q_wdata;

	// queue to back end
	logic      q_empty;
	logic      q_rd;
	wpda_cmd_t q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_REVERSE_LEFT:  cfg_q.reverse_left  <= cfg_wdata[0];
				CFG_REVERSE_RIGHT: cfg_q.reverse_right <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// decode and accept
	wpda_front u_front (
		.push   (push),
		.full   (full),
		.item   (item),
		.q_wr   (q_wr),
		.q_data (q_wdata),
		.q_full (q_full)
	);

	// decoupling queue, lets the back end stall without blocking the input until it fills
	wpda_cmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (q_wdata),
		.full    (q_full),
		.rd_en   (q_rd),
		.rd_data (q_rdata),
		.empty   (q_empty)
	);

	// execute and present the result
	wpda_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (~q_empty),
		.cmd       (q_rdata),
		.cmd_take  (q_rd),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

// File: rtl/wpda_checker.sv
// port-level checks on the accumulator, bound to the top level
module wpda_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                push,
	input logic                full,
	input logic                empty,
	input logic                pop,
	input wpda_pkg::wpda_out_t result
);
	import wpda_pkg::*;

	// a result appears only after an accepted item has passed the queue and the execute stage
	a_result_follows_push: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(empty) |-> $past(push && !full, 2))
		else $error("result appeared without a preceding transaction");

	// tracking mode never shows with no trackers registered
	a_tracking_has_trackers: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.mode == MODE_TRACKING) |-> (result.trackers != '0))
		else $error("tracking mode with zero trackers");

	// an acknowledged autocal end always leaves the autocal modes
	a_ack_leaves_autocal: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.ack) |->
			(result.mode != MODE_CAL_START && result.mode != MODE_CAL_RUN))
		else $error("ack with autocal mode still set");

	// a stalled result stays and holds its value
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("stalled result changed or vanished");

endmodule

bind wrapping_position_delta_accumulator wpda_checker u_wpda_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
